FILE: src/matrix_chain_cost_evaluator_defines.svh
// ----------------------------------------------------------------------------
// Matrix chain cost evaluator assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MATRIX_CHAIN_COST_EVALUATOR_DEFINES_SVH
`define MATRIX_CHAIN_COST_EVALUATOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MCCE_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MCCE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/mcce_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix chain cost evaluator package
// Sizes, character codes, control word types and the microcode ROM.
// ----------------------------------------------------------------------------
package mcce_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int DIM_BITS    = 8;
  localparam int TABLE_SIZE  = 26;
  localparam int TBL_W       = $clog2(TABLE_SIZE);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int SP_W        = $clog2(STACK_DEPTH);
  localparam int COST_W      = 32;
  localparam int PROD1_W     = 2 * DIM_BITS;
  localparam int PROD2_W     = 3 * DIM_BITS;
  localparam int SUM_W       = ((PROD2_W > COST_W) ? PROD2_W : COST_W) + 1;
  localparam int UPC_W       = 5;

  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_Z     = 8'h5A;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;

  localparam logic [COST_W-1:0] COST_MAX = '1;

  localparam logic [UPC_W-1:0] S_IDLE  = 5'd0;
  localparam logic [UPC_W-1:0] S_SYM   = 5'd3;
  localparam logic [UPC_W-1:0] S_CLOSE = 5'd9;
  localparam logic [UPC_W-1:0] S_ERR   = 5'd11;
  localparam logic [UPC_W-1:0] S_LAST  = 5'd12;
  localparam logic [UPC_W-1:0] S_MERGE = 5'd15;
  localparam logic [UPC_W-1:0] S_EMIT  = 5'd19;

  typedef struct packed {
    logic [DIM_BITS-1:0] rows;
    logic [DIM_BITS-1:0] cols;
  } dims_t;

  typedef enum logic [3:0] {
    A_NONE, A_LD_TBL, A_RD_TBL, A_PUSH, A_SET_ERR,
    A_RD_STK, A_MUL1, A_MUL2, A_ACC, A_EMIT
  } act_t;

  typedef enum logic [3:0] {
    C_ALWAYS, C_REQ, C_SYM, C_ERR, C_OPEN, C_CLOSE, C_LETTER,
    C_FULL, C_GE2, C_ZERO, C_LAST, C_MISM, C_OBUSY
  } cond_t;

  typedef struct packed {
    act_t             act;
    cond_t            cond;
    logic             neg;
    logic [UPC_W-1:0] target;
  } uword_t;

  typedef struct packed {
    logic idle;
    act_t act;
  } ctl_t;

  typedef struct packed {
    logic req;
    logic sym;
    logic err;
    logic open;
    logic close;
    logic letter;
    logic full;
    logic ge2;
    logic zero;
    logic last;
    logic mism;
    logic obusy;
  } stat_t;

  function automatic uword_t uw(input act_t a, input cond_t c, input logic n,
                                input logic [UPC_W-1:0] t);
    uword_t w;
    w.act    = a;
    w.cond   = c;
    w.neg    = n;
    w.target = t;
    return w;
  endfunction

  // A jump is taken when the condition, optionally inverted, is true.
  // An inverted C_ALWAYS never jumps and falls through to the next step.
  function automatic uword_t ucode_rom(input logic [UPC_W-1:0] step);
    uword_t w;
    case (step)
      5'd0:    w = uw(A_NONE,    C_REQ,    1'b1, S_IDLE);
      5'd1:    w = uw(A_NONE,    C_SYM,    1'b0, S_SYM);
      5'd2:    w = uw(A_LD_TBL,  C_ALWAYS, 1'b0, S_IDLE);
      5'd3:    w = uw(A_NONE,    C_ERR,    1'b0, S_LAST);
      5'd4:    w = uw(A_NONE,    C_OPEN,   1'b0, S_LAST);
      5'd5:    w = uw(A_NONE,    C_CLOSE,  1'b0, S_CLOSE);
      5'd6:    w = uw(A_NONE,    C_LETTER, 1'b1, S_ERR);
      5'd7:    w = uw(A_RD_TBL,  C_FULL,   1'b0, S_ERR);
      5'd8:    w = uw(A_PUSH,    C_ALWAYS, 1'b0, S_LAST);
      5'd9:    w = uw(A_NONE,    C_GE2,    1'b0, S_MERGE);
      5'd10:   w = uw(A_NONE,    C_ZERO,   1'b1, S_LAST);
      5'd11:   w = uw(A_SET_ERR, C_ALWAYS, 1'b1, S_IDLE);
      5'd12:   w = uw(A_NONE,    C_LAST,   1'b1, S_IDLE);
      5'd13:   w = uw(A_NONE,    C_ERR,    1'b0, S_EMIT);
      5'd14:   w = uw(A_NONE,    C_GE2,    1'b1, S_EMIT);
      5'd15:   w = uw(A_RD_STK,  C_ALWAYS, 1'b1, S_IDLE);
      5'd16:   w = uw(A_MUL1,    C_MISM,   1'b0, S_ERR);
      5'd17:   w = uw(A_MUL2,    C_ALWAYS, 1'b1, S_IDLE);
      5'd18:   w = uw(A_ACC,     C_ALWAYS, 1'b0, S_LAST);
      5'd19:   w = uw(A_NONE,    C_OBUSY,  1'b0, S_EMIT);
      5'd20:   w = uw(A_EMIT,    C_ALWAYS, 1'b0, S_IDLE);
      default: w = uw(A_NONE,    C_ALWAYS, 1'b0, S_IDLE);
    endcase
    return w;
  endfunction

endpackage

FILE: src/mcce_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix chain cost evaluator sequencer
// Step counter over the microcode ROM with conditional jumps on datapath status.
// ----------------------------------------------------------------------------
module mcce_seq
  import mcce_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  stat_t stat,
  output ctl_t  ctl
);

  logic [UPC_W-1:0] upc_r;
  logic [UPC_W-1:0] upc_nxt;
  uword_t           uword;
  logic             hit;

  assign uword = ucode_rom(upc_r);

  always_comb begin
    case (uword.cond)
      C_ALWAYS: hit = 1'b1;
      C_REQ:    hit = stat.req;
      C_SYM:    hit = stat.sym;
      C_ERR:    hit = stat.err;
      C_OPEN:   hit = stat.open;
      C_CLOSE:  hit = stat.close;
      C_LETTER: hit = stat.letter;
      C_FULL:   hit = stat.full;
      C_GE2:    hit = stat.ge2;
      C_ZERO:   hit = stat.zero;
      C_LAST:   hit = stat.last;
      C_MISM:   hit = stat.mism;
      C_OBUSY:  hit = stat.obusy;
      default:  hit = 1'b0;
    endcase
    upc_nxt = (hit ^ uword.neg) ? uword.target : upc_r + UPC_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= S_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

  assign ctl.idle = (upc_r == S_IDLE);
  assign ctl.act  = uword.act;

endmodule

FILE: src/mcce_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix chain cost evaluator datapath
// Size table, size stack with a cached top entry, two-step multiplier,
// saturating cost accumulator and the result register.
// ----------------------------------------------------------------------------
`include "matrix_chain_cost_evaluator_defines.svh"

module mcce_datapath
  import mcce_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  ctl_t              ctl,
  input  logic              in_fire,
  input  logic              in_action,
  input  logic [4:0]        in_letter,
  input  logic [7:0]        in_rows,
  input  logic [7:0]        in_cols,
  input  logic [7:0]        in_symbol,
  input  logic              in_last,
  input  logic              out_tready,
  output logic              out_tvalid,
  output logic [COST_W-1:0] out_cost,
  output logic              out_failed,
  output stat_t             stat
);

  logic               act_r;
  logic [4:0]         letter_r;
  logic [7:0]         rows_r;
  logic [7:0]         cols_r;
  logic [7:0]         symbol_r;
  logic               last_r;

  dims_t              tbl_mem [TABLE_SIZE];
  dims_t              stk_mem [STACK_DEPTH];
  dims_t              tbl_rd_r;
  dims_t              stk_rd_r;
  dims_t              top_r;
  dims_t              top_nxt;

  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   count_nxt;
  logic [COST_W-1:0]  cost_r;
  logic [COST_W-1:0]  cost_nxt;
  logic               err_r;
  logic               err_nxt;
  logic               out_valid_r;
  logic               out_valid_nxt;
  logic [COST_W-1:0]  out_cost_r;
  logic               out_failed_r;

  logic [PROD1_W-1:0] prod1_r;
  logic [PROD2_W-1:0] prod2_r;
  logic [SUM_W-1:0]   sum;
  logic [7:0]         sym_off;
  logic [CNT_W-1:0]   cnt_m1;
  logic [CNT_W-1:0]   cnt_m2;

  assign sym_off = symbol_r - CH_A;
  assign cnt_m1  = count_r - CNT_W'(1);
  assign cnt_m2  = count_r - CNT_W'(2);
  assign sum     = SUM_W'(cost_r) + SUM_W'(prod2_r);

  always_ff @(posedge clk) begin
    if (in_fire) begin
      act_r    <= in_action;
      letter_r <= in_letter;
      rows_r   <= in_rows;
      cols_r   <= in_cols;
      symbol_r <= in_symbol;
      last_r   <= in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.act == A_LD_TBL && letter_r < TBL_W'(TABLE_SIZE)) begin
      tbl_mem[letter_r] <= '{rows: DIM_BITS'(rows_r), cols: DIM_BITS'(cols_r)};
    end
    if (ctl.act == A_RD_TBL) begin
      tbl_rd_r <= tbl_mem[sym_off[TBL_W-1:0]];
    end
  end

  // The top entry lives in top_r; the memory holds the entries below it.
  always_ff @(posedge clk) begin
    if (ctl.act == A_PUSH && count_r != '0) begin
      stk_mem[cnt_m1[SP_W-1:0]] <= top_r;
    end
    if (ctl.act == A_RD_STK) begin
      stk_rd_r <= stk_mem[cnt_m2[SP_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.act == A_MUL1) begin
      prod1_r <= PROD1_W'(stk_rd_r.rows) * PROD1_W'(stk_rd_r.cols);
    end
    if (ctl.act == A_MUL2) begin
      prod2_r <= PROD2_W'(prod1_r) * PROD2_W'(top_r.cols);
    end
    if (ctl.act == A_EMIT) begin
      out_cost_r   <= err_r ? '0 : cost_r;
      out_failed_r <= err_r;
    end
  end

  always_comb begin
    count_nxt     = count_r;
    cost_nxt      = cost_r;
    err_nxt       = err_r;
    top_nxt       = top_r;
    out_valid_nxt = out_valid_r && !out_tready;
    case (ctl.act)
      A_PUSH: begin
        count_nxt = count_r + CNT_W'(1);
        top_nxt   = tbl_rd_r;
      end
      A_SET_ERR: begin
        err_nxt = 1'b1;
      end
      A_ACC: begin
        cost_nxt  = (|sum[SUM_W-1:COST_W]) ? COST_MAX : sum[COST_W-1:0];
        count_nxt = cnt_m1;
        top_nxt   = '{rows: stk_rd_r.rows, cols: top_r.cols};
      end
      A_EMIT: begin
        count_nxt     = '0;
        cost_nxt      = '0;
        err_nxt       = 1'b0;
        out_valid_nxt = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    top_r <= top_nxt;
    if (!rst_n) begin
      count_r     <= '0;
      cost_r      <= '0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      cost_r      <= cost_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign stat.req    = in_fire;
  assign stat.sym    = act_r;
  assign stat.err    = err_r;
  assign stat.open   = (symbol_r == CH_OPEN);
  assign stat.close  = (symbol_r == CH_CLOSE);
  assign stat.letter = symbol_r inside {[CH_A:CH_Z]};
  assign stat.full   = (count_r == CNT_W'(STACK_DEPTH));
  assign stat.ge2    = (count_r >= CNT_W'(2));
  assign stat.zero   = (count_r == '0);
  assign stat.last   = last_r;
  assign stat.mism   = (stk_rd_r.cols != top_r.rows);
  assign stat.obusy  = out_valid_r && !out_tready;

  assign out_tvalid = out_valid_r;
  assign out_cost   = out_cost_r;
  assign out_failed = out_failed_r;

  `MCCE_ASSERT_IMPL(a_count_bound, 1'b1, count_r <= CNT_W'(STACK_DEPTH), "stack count beyond depth")
  `MCCE_ASSERT_IMPL(a_emit_slot, ctl.act == A_EMIT, !out_valid_r, "result written over a pending one")
  `MCCE_ASSERT_NEXT(a_emit_clears, ctl.act == A_EMIT, (count_r == '0) && !err_r && (cost_r == '0) && out_valid_r, "expression state not cleared after result")
  `MCCE_ASSERT_NEXT(a_merge_pops, ctl.act == A_ACC, count_r == $past(count_r) - CNT_W'(1), "merge did not pop one entry")

endmodule

FILE: src/matrix_chain_cost_evaluator.sv
`timescale 1ns / 1ps
// Load requests, letters, '(' and a merging ')' each run their own sequence of microcode steps.
// Pairs left at the end are reduced before the result is emitted; after an error none are reduced.
// Throughput is set by the microcode sequencer, which steps one control word a cycle.
// Reset (rst_n low, synchronous) clears the stack count, cost, error flag and result valid.
// The size table and stack contents are not cleared by reset.
// ----------------------------------------------------------------------------
// Matrix chain cost evaluator
// Evaluates the scalar multiplication cost of a streamed matrix chain expression.
// ----------------------------------------------------------------------------
module matrix_chain_cost_evaluator
  import mcce_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // letter[4:0], rows[12:5], cols[20:13], symbol[28:21]
  input  logic        in_tuser,   // action
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // cost[31:0]
  output logic        out_tuser   // failed
);

  ctl_t  ctl;
  stat_t stat;
  logic  in_fire;

  assign in_tready = ctl.idle && rst_n;
  assign in_fire   = in_tvalid && in_tready;

  mcce_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctl   (ctl)
  );

  mcce_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .in_fire    (in_fire),
    .in_action  (in_tuser),
    .in_letter  (in_tdata[4:0]),
    .in_rows    (in_tdata[12:5]),
    .in_cols    (in_tdata[20:13]),
    .in_symbol  (in_tdata[28:21]),
    .in_last    (in_tlast),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_cost   (out_tdata),
    .out_failed (out_tuser),
    .stat       (stat)
  );

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix chain cost evaluator testbench
// Streams size-table loads and expression symbols into the evaluator. Each
// request is fed to a local model of the evaluator when the block accepts it.
// Every returned cost and error flag is compared with the oldest predicted
// result. A short directed part comes first. It is followed by random chains
// of compatible sizes, broken expressions, noise, a saturating expression and
// a stack overflow, with random idle bursts on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  import mcce_pkg::*;

  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_SYMBOL = 1'b1;

  typedef struct packed {
    logic       action;
    logic [4:0] letter;
    logic [7:0] rows;
    logic [7:0] cols;
    logic [7:0] symbol;
    logic       last;
  } request_t;

  typedef struct packed {
    logic [COST_W-1:0] cost;
    logic              failed;
  } chain_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tuser;

  request_t      pending[$];
  request_t      next_req;
  chain_result_t chain_cost_q[$];
  chain_result_t cost_want;
  int            in_accepted = 0;
  int            in_gap = 0;
  int            out_gap = 0;
  int            mismatches = 0;

  dims_t             size_tbl[TABLE_SIZE];
  dims_t             size_stk[STACK_DEPTH];
  int                stk_count = 0;
  logic [COST_W-1:0] cost_sum = '0;
  bit                chain_err = 1'b0;

  bit tbl_loaded[TABLE_SIZE];
  int chain_base = 0;
  int chain_len = 0;

  matrix_chain_cost_evaluator uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic fold_top_pair();
    dims_t       lhs;
    dims_t       rhs;
    logic [63:0] total;
    rhs = size_stk[stk_count-1];
    lhs = size_stk[stk_count-2];
    if (lhs.cols != rhs.rows) begin
      chain_err = 1'b1;
    end else begin
      total = 64'(cost_sum) + 64'(lhs.rows) * 64'(lhs.cols) * 64'(rhs.cols);
      cost_sum = (total > 64'(COST_MAX)) ? COST_MAX : total[COST_W-1:0];
      stk_count = stk_count - 1;
      size_stk[stk_count-1].rows = lhs.rows;
      size_stk[stk_count-1].cols = rhs.cols;
    end
  endtask

  task automatic step_symbol(input logic [7:0] ch);
    if (chain_err || ch == CH_OPEN) begin
    end else if (ch == CH_CLOSE) begin
      if (stk_count >= 2) begin
        fold_top_pair();
      end else if (stk_count == 0) begin
        chain_err = 1'b1;
      end
    end else if (ch >= CH_A && ch <= CH_Z) begin
      if (stk_count >= STACK_DEPTH) begin
        chain_err = 1'b1;
      end else begin
        size_stk[stk_count] = size_tbl[ch - CH_A];
        stk_count = stk_count + 1;
      end
    end else begin
      chain_err = 1'b1;
    end
  endtask

  task automatic predict_request(input logic act, input logic [31:0] data, input logic fin);
    logic [4:0]    idx;
    chain_result_t res;
    idx = data[4:0];
    if (act == ACT_LOAD) begin
      if (idx < TABLE_SIZE) begin
        size_tbl[idx].rows = data[12:5];
        size_tbl[idx].cols = data[20:13];
      end
    end else begin
      step_symbol(data[28:21]);
      if (fin) begin
        while (!chain_err && stk_count > 1) fold_top_pair();
        res.cost = chain_err ? '0 : cost_sum;
        res.failed = chain_err;
        chain_cost_q.insert(chain_cost_q.size(), res);
        stk_count = 0;
        cost_sum = '0;
        chain_err = 1'b0;
      end
    end
  endtask

  task automatic flag_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("Mismatch in %s at %0t ns: expected %0d, got %0d", what, $time, want, got);
    end
  endtask

  function automatic bit idling_on();
    return pending.size() >= 150 && ((in_accepted / 128) % 3 != 2);
  endfunction

  function automatic logic [7:0] letter_char(input int idx);
    return CH_A + 8'(idx);
  endfunction

  function automatic logic [7:0] pick_dim();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2, 3:    return 8'($urandom);
      default: return 8'($urandom_range(1, 16));
    endcase
  endfunction

  function automatic logic [7:0] junk_char();
    logic [7:0] c;
    do c = 8'($urandom);
    while ((c >= CH_A && c <= CH_Z) || c == CH_OPEN || c == CH_CLOSE);
    return c;
  endfunction

  function automatic int pick_loaded();
    int idx;
    do idx = $urandom_range(0, TABLE_SIZE - 1);
    while (!tbl_loaded[idx]);
    return idx;
  endfunction

  function automatic request_t load_req(input int idx, input logic [7:0] r,
                                        input logic [7:0] c);
    request_t q;
    q.action = ACT_LOAD;
    q.letter = idx[4:0];
    q.rows = r;
    q.cols = c;
    q.symbol = 8'($urandom);
    q.last = 1'($urandom);
    if (idx < TABLE_SIZE) tbl_loaded[idx] = 1'b1;
    return q;
  endfunction

  function automatic request_t sym_req(input logic [7:0] ch);
    request_t q;
    q.action = ACT_SYMBOL;
    q.letter = 5'($urandom);
    q.rows = 8'($urandom);
    q.cols = 8'($urandom);
    q.symbol = ch;
    q.last = 1'b0;
    return q;
  endfunction

  task automatic enqueue(input request_t q);
    pending.insert(pending.size(), q);
  endtask

  task automatic put_sym(input logic [7:0] ch, input bit fin);
    request_t q;
    q = sym_req(ch);
    q.last = fin;
    enqueue(q);
  endtask

  task automatic queue_expression(input bit broken);
    request_t   toks[$];
    int         depth;
    int         i;
    int         pos;
    logic [7:0] prev_dim;
    logic [7:0] next_dim;
    if (chain_len == 0 || $urandom_range(0, 1) == 0) begin
      chain_len = ($urandom_range(0, 19) == 0) ? $urandom_range(9, TABLE_SIZE)
                                                : $urandom_range(1, 8);
      chain_base = $urandom_range(0, TABLE_SIZE - 1);
      prev_dim = pick_dim();
      for (i = 0; i < chain_len; i++) begin
        next_dim = pick_dim();
        enqueue(load_req((chain_base + i) % TABLE_SIZE, prev_dim, next_dim));
        prev_dim = next_dim;
      end
    end
    depth = 0;
    for (i = 0; i < chain_len; i++) begin
      if ($urandom_range(0, 3) == 0) toks.insert(toks.size(), sym_req(CH_OPEN));
      toks.insert(toks.size(), sym_req(letter_char((chain_base + i) % TABLE_SIZE)));
      depth++;
      while (depth >= 2 && $urandom_range(0, 2) == 0) begin
        toks.insert(toks.size(), sym_req(CH_CLOSE));
        depth--;
      end
      if (depth == 1 && $urandom_range(0, 9) == 0) toks.insert(toks.size(), sym_req(CH_CLOSE));
    end
    while (depth >= 2 && $urandom_range(0, 1) == 0) begin
      toks.insert(toks.size(), sym_req(CH_CLOSE));
      depth--;
    end
    if ($urandom_range(0, 9) == 0) toks.insert(toks.size(), sym_req(CH_OPEN));
    if (broken) begin
      case ($urandom_range(0, 3))
        0: begin
          do pos = $urandom_range(0, toks.size() - 1);
          while (toks[pos].symbol == CH_OPEN || toks[pos].symbol == CH_CLOSE);
          toks[pos].symbol = letter_char(pick_loaded());
        end
        1: toks.insert($urandom_range(0, toks.size()), sym_req(junk_char()));
        2: toks.push_front(sym_req(CH_CLOSE));
        default: toks.insert($urandom_range(0, toks.size() - 1),
                             load_req($urandom_range(0, 31), pick_dim(), pick_dim()));
      endcase
    end
    toks[toks.size()-1].last = 1'b1;
    foreach (toks[j]) enqueue(toks[j]);
  endtask

  task automatic queue_noise();
    case ($urandom_range(0, 4))
      0, 1:    enqueue(load_req($urandom_range(0, 31), 8'($urandom), 8'($urandom)));
      2:       put_sym(junk_char(), 1'b1);
      3:       put_sym($urandom_range(0, 1) ? CH_CLOSE : CH_OPEN, 1'b1);
      default: put_sym(letter_char(pick_loaded()), 1'b1);
    endcase
  endtask

  task automatic queue_random_until(input int target);
    int pick;
    while (pending.size() < target) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        queue_noise();
      end else begin
        queue_expression(pick == 1);
      end
    end
  endtask

  task automatic queue_saturating_chain();
    int i;
    enqueue(load_req(16, 8'hFF, 8'hFF));
    for (i = 0; i < STACK_DEPTH - 1; i++) put_sym(letter_char(16), 1'b0);
    for (i = 0; i < 200; i++) begin
      put_sym(letter_char(16), 1'b0);
      put_sym(CH_CLOSE, i == 199);
    end
  endtask

  task automatic queue_overflow_chain();
    int i;
    enqueue(load_req(7, 8'd3, 8'd3));
    for (i = 0; i <= STACK_DEPTH; i++) put_sym(letter_char(7), i == STACK_DEPTH);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap <= 0;
    end else begin
      if (in_tvalid && in_tready) in_accepted <= in_accepted + 1;
      if (!in_tvalid || in_tready) begin
        if (in_gap != 0) begin
          in_gap <= in_gap - 1;
          in_tvalid <= 1'b0;
        end else if (idling_on() && $urandom_range(0, 9) == 0) begin
          in_gap <= $urandom_range(0, 16);
          in_tvalid <= 1'b0;
        end else if (pending.size() != 0) begin
          next_req = pending.pop_front();
          in_tdata <= {3'b000, next_req.symbol, next_req.cols, next_req.rows, next_req.letter};
          in_tuser <= next_req.action;
          in_tlast <= next_req.last;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_gap <= 0;
    end else if (out_gap != 0) begin
      out_gap <= out_gap - 1;
      out_tready <= 1'b0;
    end else if (idling_on() && $urandom_range(0, 9) == 0) begin
      out_gap <= $urandom_range(0, 16);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) predict_request(in_tuser, in_tdata, in_tlast);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (chain_cost_q.size() == 0) begin
        flag_mismatch("cost of a result with none outstanding", 32'd0, out_tdata);
      end else begin
        cost_want = chain_cost_q.pop_front();
        if (out_tdata !== cost_want.cost) flag_mismatch("cost", cost_want.cost, out_tdata);
        if (out_tuser !== cost_want.failed) begin
          flag_mismatch("failed flag", 32'(cost_want.failed), 32'(out_tuser));
        end
      end
    end
  end

  initial begin
    enqueue(load_req(0, 8'd10, 8'd20));
    enqueue(load_req(1, 8'd20, 8'd30));
    enqueue(load_req(2, 8'd30, 8'd5));
    enqueue(load_req(25, 8'hFF, 8'hFF));
    enqueue(load_req(24, 8'h00, 8'h00));
    enqueue(load_req(31, 8'hFF, 8'hFF));
    put_sym(CH_OPEN, 1'b0);
    put_sym(letter_char(0), 1'b0);
    put_sym(letter_char(1), 1'b0);
    put_sym(CH_CLOSE, 1'b0);
    put_sym(letter_char(2), 1'b1);
    put_sym(letter_char(0), 1'b0);
    put_sym(CH_CLOSE, 1'b1);
    put_sym(CH_CLOSE, 1'b1);
    put_sym(letter_char(0), 1'b0);
    put_sym(letter_char(2), 1'b0);
    put_sym(CH_CLOSE, 1'b0);
    put_sym(letter_char(1), 1'b1);
    put_sym(8'hFF, 1'b1);
    put_sym(CH_OPEN, 1'b1);
    put_sym(letter_char(25), 1'b0);
    put_sym(letter_char(25), 1'b1);
    put_sym(letter_char(24), 1'b0);
    put_sym(letter_char(24), 1'b1);

    queue_random_until(350);
    queue_saturating_chain();
    queue_random_until(900);
    queue_overflow_chain();
    queue_random_until(1150);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (pending.size() != 0 || in_tvalid || chain_cost_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS matrix_chain_cost_evaluator");
    end else begin
      $display("FAIL matrix_chain_cost_evaluator");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL matrix_chain_cost_evaluator");
    $finish;
  end

endmodule

FILE: files.f
+incdir+src
src/mcce_pkg.sv
src/mcce_seq.sv
src/mcce_datapath.sv
src/matrix_chain_cost_evaluator.sv
tb/tb_top.sv
